/* rtl/rccs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the clique select unit.
package rccs_pkg;

  localparam int COORD_W  = 20;
  localparam int PACK_W   = 3 * COORD_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ROW_W    = 64;
  localparam int DIST_LAT = 3 + ROOT_W;

  localparam logic [COORD_W-1:0] DELTA_RESET = 20'd205;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_a_z;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_b_z;
    logic                      last_match;
  } in_item_t;

  typedef struct packed {
    idx_t inlier_index;
    logic last_inlier;
    logic overflowed;
  } out_item_t;

  typedef struct packed {
    logic [PACK_W-1:0] a;
    logic [PACK_W-1:0] b;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  deg;
    idx_t              tag;
    logic              cand;
  } cell_data_t;

  typedef struct packed {
    logic hit;
    idx_t tag;
    idx_t col;
  } cell_upd_t;

  typedef struct packed {
    logic       en;
    cell_data_t data;
  } cell_load_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DRAIN,
    ST_STORE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

/* rtl/rccs_cell.sv */
`timescale 1ns / 1ps
// One ring cell: holds a stored match, its consistency row and degree.
module rccs_cell #(
  parameter rccs_pkg::idx_t HOME = '0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  rccs_pkg::cell_data_t nb,
  input  rccs_pkg::cell_load_t load,
  input  rccs_pkg::cell_upd_t  upd,
  output rccs_pkg::cell_data_t q_out
);

  rccs_pkg::cell_data_t q;
  rccs_pkg::cell_data_t q_upd;

  // pair result lands on whichever cell currently holds the tagged match
  always_comb begin
    q_upd = q;
    if (upd.hit && upd.tag == q.tag) begin
      q_upd.row[upd.col] = 1'b1;
      q_upd.deg          = q.deg + 7'd1;
    end
  end

  assign q_out = q_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.tag <= HOME;
    end else if (shift) begin
      q <= nb;
    end else if (load.en && load.data.tag == q.tag) begin
      q <= load.data;
    end else begin
      q <= q_upd;
    end
  end

endmodule

/* rtl/rccs_dist.sv */
`timescale 1ns / 1ps
// Pipelined Euclidean distance: differences, squares, sum, digit-by-digit root.
module rccs_dist (
  input  logic                          clk,
  input  logic [rccs_pkg::PACK_W-1:0]   p,
  input  logic [rccs_pkg::PACK_W-1:0]   q,
  output logic [rccs_pkg::ROOT_W-1:0]   root
);

  localparam int CW = rccs_pkg::COORD_W;
  localparam int DW = rccs_pkg::DIFF_W;
  localparam int RW = rccs_pkg::ROOT_W;
  localparam int MW = rccs_pkg::REM_W;
  localparam int VW = rccs_pkg::SUM_W;

  logic [2:0][DW-1:0]             mag;
  logic [2:0][rccs_pkg::SQ_W-1:0] sq;
  logic [VW-1:0]                  sum;

  logic [VW-1:0] vs [RW];
  logic [MW-1:0] rs [RW];
  logic [RW-1:0] qs [RW];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [DW-1:0] d;
      d = $signed({p[CW*k+CW-1], p[CW*k +: CW]}) - $signed({q[CW*k+CW-1], q[CW*k +: CW]});
      mag[k] <= d[DW-1] ? DW'(-d) : DW'(d);
    end
    for (int k = 0; k < 3; k++) begin
      sq[k] <= mag[k] * mag[k];
    end
    sum <= VW'(sq[0]) + VW'(sq[1]) + VW'(sq[2]);
  end

  for (genvar s = 0; s < RW; s++) begin : g_root
    logic [VW-1:0] v_in;
    logic [MW-1:0] r_in;
    logic [RW-1:0] q_in;
    logic [MW+1:0] rem_n;
    logic [MW+1:0] trial;

    if (s == 0) begin : g_first
      assign v_in = sum;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vs[s-1];
      assign r_in = rs[s-1];
      assign q_in = qs[s-1];
    end

    assign rem_n = {r_in, v_in[VW-1 -: 2]};
    assign trial = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      vs[s] <= v_in << 2;
      if (rem_n >= trial) begin
        rs[s] <= MW'(rem_n - trial);
        qs[s] <= {q_in[RW-2:0], 1'b1};
      end else begin
        rs[s] <= MW'(rem_n);
        qs[s] <= {q_in[RW-2:0], 1'b0};
      end
    end
  end

  assign root = qs[RW-1];

endmodule

/* rtl/rigid_consistency_clique_select_unit.sv */
`timescale 1ns / 1ps
// Top level: match store ring, pair distance pipeline and greedy clique search.
//
// Matches arrive on in_valid/in_ready, one 3D point pair per transfer. Each
// accepted match rotates the ring of MAX_MATCHES cells once past the two
// distance pipelines (DIST_LAT = 25 stages), then waits for them to drain
// before it is stored; in_ready is high only when the unit is idle.
// Once the set is full, further matches are dropped and flagged.
// A match with last_match starts the clique search: each member takes one
// full ring rotation plus an emit step, and one further rotation finds that
// nothing is left. Members leave on out_valid/out_ready in order of
// selection, the final one with last_inlier set. A stalled receiver
// holds the search at its next member; one result waits in the output
// register while the next is being searched. The threshold is written on
// cfg_valid/cfg_ready, always ready, and must only change while idle.
// Synchronous reset empties the set and restores the threshold to 205;
// stored points are not cleared.
module rigid_consistency_clique_select_unit #(
  parameter int MAX_MATCHES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rccs_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rccs_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [rccs_pkg::COORD_W-1:0] cfg_data
);

  localparam int LAT = rccs_pkg::DIST_LAT;
  localparam int CW  = rccs_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_MATCHES);
  localparam logic [CW-1:0] LASTT = CW'(MAX_MATCHES - 1);

  rccs_pkg::state_t state, state_next;

  logic [CW-1:0]                 t;
  logic [CW-1:0]                 count;
  logic                          overflow_seen;
  logic [rccs_pkg::COORD_W-1:0]  delta;
  logic [rccs_pkg::PACK_W-1:0]   na, nb;
  logic                          nlast;
  logic [rccs_pkg::ROW_W-1:0]    new_row;
  logic [CW-1:0]                 new_deg;
  logic [LAT-1:0]                vpipe;
  rccs_pkg::idx_t                tpipe [LAT];
  logic                          found, first, pend_valid;
  rccs_pkg::idx_t                best_idx, prev_best, pend_idx;
  logic [CW-1:0]                 best_deg;
  logic [rccs_pkg::ROW_W-1:0]    cur_row, sel_row;

  rccs_pkg::cell_data_t cell_q  [MAX_MATCHES];
  rccs_pkg::cell_data_t cell_in [MAX_MATCHES];
  rccs_pkg::cell_data_t head, head_mod;
  rccs_pkg::cell_upd_t  upd;
  rccs_pkg::cell_load_t load;

  logic                        shift, issue, out_free, cand_new, better, hit, out_load;
  logic [rccs_pkg::ROOT_W-1:0] da, db, ddiff;

  assign in_ready  = (state == rccs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign shift     = (state == rccs_pkg::ST_CMP) || (state == rccs_pkg::ST_SCAN);
  assign issue     = (state == rccs_pkg::ST_CMP) && (t < count);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == rccs_pkg::ST_EMIT) && out_free && (!found || pend_valid);

  // ring of cells; the head feeds the distance units and the search logic
  assign head = cell_q[0];

  always_comb begin
    head_mod = head;
    if (first) begin
      cand_new = ({1'b0, head.tag} < count);
    end else begin
      cand_new = head.cand && sel_row[head.tag] && (head.tag != prev_best);
    end
    if (state == rccs_pkg::ST_SCAN) begin
      head_mod.cand = cand_new;
    end
    better = cand_new && (!found || head.deg > best_deg);
  end

  for (genvar k = 0; k < MAX_MATCHES; k++) begin : g_cell
    if (k == MAX_MATCHES - 1) begin : g_tail
      assign cell_in[k] = head_mod;
    end else begin : g_body
      assign cell_in[k] = cell_q[k+1];
    end
    rccs_cell #(.HOME(rccs_pkg::idx_t'(k))) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .nb    (cell_in[k]),
      .load  (load),
      .upd   (upd),
      .q_out (cell_q[k])
    );
  end

  rccs_dist u_dist_a (.clk(clk), .p(head.a), .q(na), .root(da));
  rccs_dist u_dist_b (.clk(clk), .p(head.b), .q(nb), .root(db));

  assign ddiff = (da > db) ? (da - db) : (db - da);
  assign hit   = vpipe[LAT-1] && (ddiff < rccs_pkg::ROOT_W'(delta));

  assign upd.hit = hit;
  assign upd.tag = tpipe[LAT-1];
  assign upd.col = count[rccs_pkg::IDX_W-1:0];

  always_comb begin
    load.en        = (state == rccs_pkg::ST_STORE);
    load.data.a    = na;
    load.data.b    = nb;
    load.data.row  = new_row | (rccs_pkg::ROW_W'(1) << count[rccs_pkg::IDX_W-1:0]);
    load.data.deg  = new_deg;
    load.data.tag  = count[rccs_pkg::IDX_W-1:0];
    load.data.cand = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rccs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rccs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (count < MAXC) begin
            state_next = rccs_pkg::ST_CMP;
          end else if (in_item.last_match) begin
            state_next = rccs_pkg::ST_SCAN;
          end
        end
      end
      rccs_pkg::ST_CMP: begin
        if (t == LASTT) state_next = rccs_pkg::ST_DRAIN;
      end
      rccs_pkg::ST_DRAIN: begin
        if (vpipe == '0) state_next = rccs_pkg::ST_STORE;
      end
      rccs_pkg::ST_STORE: begin
        state_next = nlast ? rccs_pkg::ST_SCAN : rccs_pkg::ST_IDLE;
      end
      rccs_pkg::ST_SCAN: begin
        if (t == LASTT) state_next = rccs_pkg::ST_EMIT;
      end
      rccs_pkg::ST_EMIT: begin
        if (found) begin
          if (!pend_valid || out_free) state_next = rccs_pkg::ST_SCAN;
        end else if (out_free) begin
          state_next = rccs_pkg::ST_IDLE;
        end
      end
      default: state_next = rccs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tpipe[0] <= t[rccs_pkg::IDX_W-1:0];
    for (int k = 1; k < LAT; k++) begin
      tpipe[k] <= tpipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t             <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
      delta         <= rccs_pkg::DELTA_RESET;
      vpipe         <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      found         <= 1'b0;
      first         <= 1'b1;
    end else begin
      if (cfg_valid) delta <= cfg_data;
      vpipe <= {vpipe[LAT-2:0], issue};
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (hit) begin
        new_row[tpipe[LAT-1]] <= 1'b1;
        new_deg               <= new_deg + 7'd1;
      end

      case (state)
        rccs_pkg::ST_IDLE: begin
          if (in_valid) begin
            na      <= {in_item.point_a_z, in_item.point_a_y, in_item.point_a_x};
            nb      <= {in_item.point_b_z, in_item.point_b_y, in_item.point_b_x};
            nlast   <= in_item.last_match;
            new_row <= '0;
            new_deg <= 7'd1;
            t       <= '0;
            first   <= 1'b1;
            found   <= 1'b0;
            if (count >= MAXC) begin
              overflow_seen <= 1'b1;
              pend_valid    <= 1'b0;
            end
          end
        end
        rccs_pkg::ST_CMP: begin
          t <= (t == LASTT) ? '0 : t + 7'd1;
        end
        rccs_pkg::ST_STORE: begin
          count      <= count + 7'd1;
          first      <= 1'b1;
          found      <= 1'b0;
          pend_valid <= 1'b0;
          t          <= '0;
        end
        rccs_pkg::ST_SCAN: begin
          t <= (t == LASTT) ? '0 : t + 7'd1;
          if (better) begin
            found    <= 1'b1;
            best_idx <= head.tag;
            best_deg <= head.deg;
            cur_row  <= head.row;
          end
        end
        rccs_pkg::ST_EMIT: begin
          if (found) begin
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                out_item.inlier_index <= pend_idx;
                out_item.last_inlier  <= 1'b0;
                out_item.overflowed   <= overflow_seen;
              end
              pend_valid <= 1'b1;
              pend_idx   <= best_idx;
              sel_row    <= cur_row;
              prev_best  <= best_idx;
              first      <= 1'b0;
              found      <= 1'b0;
              t          <= '0;
            end
          end else if (out_free) begin
            out_item.inlier_index <= pend_idx;
            out_item.last_inlier  <= 1'b1;
            out_item.overflowed   <= overflow_seen;
            count                 <= '0;
            overflow_seen         <= 1'b0;
            pend_valid            <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAXC)
    else $error("match count beyond capacity");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == rccs_pkg::ST_IDLE) |-> (vpipe == '0))
    else $error("pair results still in flight while idle");

  a_final_member: assert property (@(posedge clk) disable iff (rst)
    (state == rccs_pkg::ST_EMIT && !found && out_free) |=>
      (out_valid && out_item.last_inlier && state == rccs_pkg::ST_IDLE))
    else $error("end of search did not deliver the final member");

endmodule

/* sim/rigid_consistency_clique_select_unit_test.sv */
`timescale 1ns / 1ps
// Clique select unit testbench: directed and random match sets vs a greedy clique predictor.
module rigid_consistency_clique_select_unit_test;

  localparam int NMAX = 64;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rccs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rccs_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rccs_pkg::COORD_W-1:0] cfg_data = '0;

  rigid_consistency_clique_select_unit #(.MAX_MATCHES(NMAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [rccs_pkg::COORD_W-1:0] thresh;
  logic [rccs_pkg::PACK_W-1:0] pts_a [NMAX];
  logic [rccs_pkg::PACK_W-1:0] pts_b [NMAX];
  logic [NMAX-1:0] adj [NMAX];
  int unsigned degree [NMAX];
  int unsigned stored;
  bit dropped;

  rccs_pkg::in_item_t pending_matches[$];
  rccs_pkg::out_item_t expected_inliers[$];
  int errors = 0;
  int sets_done = 0;
  int inliers_seen = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit cfg_req = 1'b0;
  logic [rccs_pkg::COORD_W-1:0] cfg_word;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned point_dist(logic [rccs_pkg::PACK_W-1:0] p,
                                                 logic [rccs_pkg::PACK_W-1:0] q);
    longint unsigned sum;
    longint d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(p[20*k +: 20])) - longint'($signed(q[20*k +: 20]));
      if (d < 0) d = -d;
      sum += longint'(d) * longint'(d);
    end
    return isqrt(sum);
  endfunction

  task automatic queue_match(rccs_pkg::in_item_t m);
    pending_matches = {pending_matches, m};
  endtask

  task automatic predict_match(rccs_pkg::in_item_t m);
    longint unsigned da, db, df;
    logic [NMAX-1:0] clique;
    int unsigned best, best_deg, n;
    bit found;
    rccs_pkg::out_item_t exp_item;
    if (stored < NMAX) begin
      n = stored;
      pts_a[n] = {m.point_a_z, m.point_a_y, m.point_a_x};
      pts_b[n] = {m.point_b_z, m.point_b_y, m.point_b_x};
      adj[n] = '0;
      adj[n][n] = 1'b1;
      degree[n] = 1;
      for (int i = 0; i < n; i++) begin
        da = point_dist(pts_a[n], pts_a[i]);
        db = point_dist(pts_b[n], pts_b[i]);
        df = da > db ? da - db : db - da;
        if (df < thresh) begin
          adj[n][i] = 1'b1;
          adj[i][n] = 1'b1;
          degree[i]++;
          degree[n]++;
        end
      end
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!m.last_match) return;
    clique = '0;
    forever begin
      found = 1'b0;
      best = 0;
      best_deg = 0;
      for (int i = 0; i < stored; i++) begin
        if (clique[i]) continue;
        if ((adj[i] & clique) != clique) continue;
        if (!found || degree[i] > best_deg) begin
          found = 1'b1;
          best = i;
          best_deg = degree[i];
        end
      end
      if (!found) break;
      clique[best] = 1'b1;
      exp_item.inlier_index = rccs_pkg::idx_t'(best);
      exp_item.last_inlier = 1'b0;
      exp_item.overflowed = dropped;
      expected_inliers = {expected_inliers, exp_item};
    end
    expected_inliers[$].last_inlier = 1'b1;
    stored = 0;
    dropped = 1'b0;
    sets_done++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
        thresh = cfg_data;
        cfg_req = 1'b0;
      end else if (cfg_req && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_data <= cfg_word;
      end
      if (in_valid && in_ready) begin
        predict_match(in_item);
        in_gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_matches.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= pending_matches.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        inliers_seen++;
        if (expected_inliers.size() == 0) begin
          report_mismatch("unexpected transfer, index", int'(out_item.inlier_index), -1);
        end else begin
          rccs_pkg::out_item_t e;
          e = expected_inliers.pop_front();
          if (out_item.inlier_index !== e.inlier_index)
            report_mismatch("inlier_index", int'(out_item.inlier_index),
                            int'(e.inlier_index));
          if (out_item.last_inlier !== e.last_inlier)
            report_mismatch("last_inlier", int'(out_item.last_inlier), int'(e.last_inlier));
          if (out_item.overflowed !== e.overflowed)
            report_mismatch("overflowed", int'(out_item.overflowed), int'(e.overflowed));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 20'h80000;
      1: return 20'h7ffff;
      default: return 20'($urandom);
    endcase
  endfunction

  // a rigid cloud: frame B is frame A shifted, with small noise; others are outliers
  function automatic rccs_pkg::in_item_t make_match(bit rigid, int shift, int noise, bit last);
    rccs_pkg::in_item_t m;
    m.point_a_x = 20'($urandom_range(0, 65535) - 32768);
    m.point_a_y = 20'($urandom_range(0, 65535) - 32768);
    m.point_a_z = 20'($urandom_range(0, 65535) - 32768);
    if (rigid) begin
      m.point_b_x = 20'(int'(m.point_a_x) + shift + int'($urandom_range(0, 2*noise)) - noise);
      m.point_b_y = 20'(int'(m.point_a_y) - shift + int'($urandom_range(0, 2*noise)) - noise);
      m.point_b_z = 20'(int'(m.point_a_z) + int'($urandom_range(0, 2*noise)) - noise);
    end else begin
      m.point_b_x = 20'($urandom_range(0, 65535) - 32768);
      m.point_b_y = 20'($urandom_range(0, 65535) - 32768);
      m.point_b_z = 20'($urandom_range(0, 65535) - 32768);
    end
    m.last_match = last;
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_matches.size() > 0 || in_valid || expected_inliers.size() > 0)
      @(posedge clk);
    repeat (NMAX * 3 + rccs_pkg::DIST_LAT + 40) @(posedge clk);
  endtask

  task automatic write_thresh(logic [rccs_pkg::COORD_W-1:0] v);
    cfg_word = v;
    cfg_req = 1'b1;
    while (cfg_req) @(posedge clk);
  endtask

  initial begin
    int total, len, shift;
    rccs_pkg::in_item_t m;
    thresh = rccs_pkg::DELTA_RESET;
    stored = 0;
    dropped = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single match set, extremes, identical points
    m = '0;
    m.point_a_x = 20'sh80000; m.point_a_y = 20'sh7ffff; m.point_a_z = 20'sh80000;
    m.point_b_x = 20'sh7ffff; m.point_b_y = 20'sh80000; m.point_b_z = 20'sh7ffff;
    m.last_match = 1'b1;
    queue_match(m);
    m.last_match = 1'b0;
    queue_match(m);
    m.point_a_x = 20'sh7ffff; m.point_b_x = 20'sh80000;
    queue_match(m);
    m = '0;
    queue_match(m);
    m.last_match = 1'b1;
    queue_match(m);
    total = 5;
    wait_drained();

    // zero threshold: only self-edges
    write_thresh(20'd0);
    for (int i = 0; i < 4; i++) queue_match(make_match(1'b1, 100, 0, i == 3));
    total += 4;
    wait_drained();

    // widest threshold, then overflow with the last flag on a dropped match
    write_thresh(20'hfffff);
    for (int i = 0; i < NMAX + 3; i++)
      queue_match(make_match((i % 2) == 1, 50, 3, i == NMAX + 2));
    total += NMAX + 3;
    wait_drained();
    write_thresh(20'd1);
    for (int i = 0; i < 6; i++) queue_match(make_match(1'b1, 0, 0, i == 5));
    total += 6;
    wait_drained();
    write_thresh(rccs_pkg::DELTA_RESET);

    // random sets, mostly small, shaped like rigid clouds with outliers
    while (total < 430) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NMAX + 2) : $urandom_range(1, 8);
      shift = $urandom_range(0, 5000);
      if (total > 380) quiet = 1'b1;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          m = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), 1'b0};
        end else begin
          m = make_match($urandom_range(0, 3) != 0, shift, $urandom_range(0, 60), 1'b0);
        end
        m.last_match = (i == len - 1);
        queue_match(m);
      end
      total += len;
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
        write_thresh($urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(1, 400)));
      end
    end

    wait_drained();
    $display("%0d matches in %0d sets, %0d inliers checked, thresholds 0 to max",
             total, sets_done, inliers_seen);
    if (errors == 0 && expected_inliers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rccs_pkg.sv
rtl/rccs_cell.sv
rtl/rccs_dist.sv
rtl/rigid_consistency_clique_select_unit.sv
sim/rigid_consistency_clique_select_unit_test.sv
